// ===== hdl/pses_pkg.sv =====
package pses_pkg;

    // Widths that the stream ports fix.
    localparam int CH_WIDTH       = 8;
    localparam int OUT_WIDTH      = 32;
    localparam int ERR_WIDTH      = 2;
    localparam int M_TDATA_WIDTH  = 40;

    // Defaults for the top-level parameters.
    localparam int DEF_STACK_DEPTH = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Characters with a meaning of their own.
    localparam logic [CH_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CH_WIDTH-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CH_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CH_WIDTH-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CH_WIDTH-1:0] CHAR_OPEN  = 8'h28;
    localparam logic [CH_WIDTH-1:0] CHAR_CLOSE = 8'h29;

    localparam logic [3:0] DECIMAL_BASE = 4'd10;

    // Character kinds as the front part classifies them.
    localparam logic [2:0] KIND_DIGIT = 3'd0;
    localparam logic [2:0] KIND_PLUS  = 3'd1;
    localparam logic [2:0] KIND_MINUS = 3'd2;
    localparam logic [2:0] KIND_OPEN  = 3'd3;
    localparam logic [2:0] KIND_CLOSE = 3'd4;
    localparam logic [2:0] KIND_OTHER = 3'd5;

    // Error codes reported with each result.
    localparam logic [ERR_WIDTH-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_WIDTH-1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [ERR_WIDTH-1:0] ERR_UNMATCHED = 2'd2;
    localparam logic [ERR_WIDTH-1:0] ERR_UNCLOSED  = 2'd3;

    // One classified character as it waits in the queue.
    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] digit;
        logic       last;
    } item_t;

endpackage

// ===== hdl/pses_ram.sv =====
module pses_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/pses_front.sv =====
module pses_front (
    input  logic [pses_pkg::CH_WIDTH-1:0] ch,
    input  logic                          last,
    output pses_pkg::item_t               item
);

    logic [pses_pkg::CH_WIDTH-1:0] ch_off;

    assign ch_off = ch - pses_pkg::CHAR_ZERO;

    always_comb begin
        item.last  = last;
        item.digit = ch_off[3:0];
        if (ch >= pses_pkg::CHAR_ZERO && ch <= pses_pkg::CHAR_NINE) begin
            item.kind = pses_pkg::KIND_DIGIT;
        end else if (ch == pses_pkg::CHAR_PLUS) begin
            item.kind = pses_pkg::KIND_PLUS;
        end else if (ch == pses_pkg::CHAR_MINUS) begin
            item.kind = pses_pkg::KIND_MINUS;
        end else if (ch == pses_pkg::CHAR_OPEN) begin
            item.kind = pses_pkg::KIND_OPEN;
        end else if (ch == pses_pkg::CHAR_CLOSE) begin
            item.kind = pses_pkg::KIND_CLOSE;
        end else begin
            item.kind = pses_pkg::KIND_OTHER;
        end
    end

endmodule

// ===== hdl/pses_queue.sv =====
module pses_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pses_pkg::item_t push_item,
    output logic            not_full,
    input  logic            pop,
    output logic            head_valid,
    output pses_pkg::item_t head
);

    localparam int DEPTH = pses_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    pses_pkg::item_t slot_reg [DEPTH];
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            do_push, do_pop;

    assign not_full   = (fill_reg != CW'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = slot_reg[rptr_reg];
    assign do_push    = push && not_full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/pses_back.sv =====
module pses_back #(
    parameter int STACK_DEPTH = pses_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = pses_pkg::DEF_VALUE_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           head_valid,
    input  pses_pkg::item_t                head,
    output logic                           pop,
    input  logic                           res_ready,
    output logic                           res_valid,
    output logic [pses_pkg::OUT_WIDTH-1:0] res_value,
    output logic [pses_pkg::ERR_WIDTH-1:0] res_error
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int FW = VALUE_WIDTH + 1;
    localparam int OW = pses_pkg::OUT_WIDTH;
    localparam int EW = pses_pkg::ERR_WIDTH;

    function automatic logic [VALUE_WIDTH-1:0] neg_if(input logic [VALUE_WIDTH-1:0] v,
                                                      input logic n);
        return n ? ('0 - v) : v;
    endfunction

    // Issue stage: stack depth and error tracking, read of the frame to pop.
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [EW-1:0] err_reg, err_next;
    logic          is_full, is_empty, push_ok, pop_ok, ovf, unm;
    logic [CW-1:0] cnt_step, cnt_dec;
    logic [EW-1:0] err_step, err_final;

    // Execute stage.
    logic                   b_valid_reg, b_valid_next;
    logic [2:0]             b_kind_reg;
    logic [3:0]             b_digit_reg;
    logic                   b_last_reg;
    logic                   b_push_reg;
    logic                   b_pop_reg;
    logic [AW-1:0]          b_waddr_reg;
    logic [EW-1:0]          b_err_reg;
    logic                   byp_reg;
    logic [FW-1:0]          byp_frame_reg;

    logic [VALUE_WIDTH-1:0] pend_reg, pend_next;
    logic [VALUE_WIDTH-1:0] sum_reg, sum_next;
    logic                   sign_reg, sign_next;

    logic                   stall, fire;
    logic [VALUE_WIDTH-1:0] fold, pend_x10, pend_step, sum_step, res_sum;
    logic                   sign_step;
    logic [FW-1:0]          ram_rdata, frame, wr_frame;
    logic [AW-1:0]          raddr;
    logic                   ram_we, ram_re;
    logic [OW-1:0]          res_ext;

    logic                   out_valid_reg, out_valid_next;
    logic [OW-1:0]          out_value_reg;
    logic [EW-1:0]          out_error_reg;

    // ---------------- issue stage ----------------
    assign stall = b_valid_reg && b_last_reg && out_valid_reg && !res_ready;
    assign fire  = b_valid_reg && !stall;
    assign pop   = head_valid && !stall;

    assign is_full  = (cnt_reg == CW'(STACK_DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign push_ok  = (head.kind == pses_pkg::KIND_OPEN) && !is_full;
    assign ovf      = (head.kind == pses_pkg::KIND_OPEN) && is_full;
    assign pop_ok   = (head.kind == pses_pkg::KIND_CLOSE) && !is_empty;
    assign unm      = (head.kind == pses_pkg::KIND_CLOSE) && is_empty;
    assign cnt_dec  = cnt_reg - 1'b1;
    assign raddr    = cnt_dec[AW-1:0];

    always_comb begin
        if (push_ok) begin
            cnt_step = cnt_reg + 1'b1;
        end else if (pop_ok) begin
            cnt_step = cnt_dec;
        end else begin
            cnt_step = cnt_reg;
        end

        // The first error of an expression is the one reported.
        if (err_reg != pses_pkg::ERR_NONE) begin
            err_step = err_reg;
        end else if (ovf) begin
            err_step = pses_pkg::ERR_OVERFLOW;
        end else if (unm) begin
            err_step = pses_pkg::ERR_UNMATCHED;
        end else begin
            err_step = pses_pkg::ERR_NONE;
        end

        if (err_step == pses_pkg::ERR_NONE && cnt_step != '0) begin
            err_final = pses_pkg::ERR_UNCLOSED;
        end else begin
            err_final = err_step;
        end

        cnt_next = cnt_reg;
        err_next = err_reg;
        if (pop) begin
            if (head.last) begin
                cnt_next = '0;
                err_next = pses_pkg::ERR_NONE;
            end else begin
                cnt_next = cnt_step;
                err_next = err_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            err_reg <= pses_pkg::ERR_NONE;
        end else begin
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

    // ---------------- frame store ----------------
    assign fold     = sum_reg + neg_if(pend_reg, sign_reg);
    assign wr_frame = {sign_reg, fold};
    assign ram_we   = fire && b_push_reg;
    assign ram_re   = pop && pop_ok;

    pses_ram #(
        .WIDTH (FW),
        .DEPTH (STACK_DEPTH)
    ) u_frames (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (b_waddr_reg),
        .wdata (wr_frame),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // A frame pushed in the same cycle as its read is forwarded from here.
    always_ff @(posedge aclk) begin
        if (pop) begin
            b_kind_reg    <= head.kind;
            b_digit_reg   <= head.digit;
            b_last_reg    <= head.last;
            b_push_reg    <= push_ok;
            b_pop_reg     <= pop_ok;
            b_waddr_reg   <= cnt_reg[AW-1:0];
            b_err_reg     <= err_final;
            byp_reg       <= ram_we && (b_waddr_reg == raddr);
            byp_frame_reg <= wr_frame;
        end
    end

    assign b_valid_next = pop || (b_valid_reg && stall);

    // ---------------- execute stage ----------------
    assign frame    = byp_reg ? byp_frame_reg : ram_rdata;
    assign pend_x10 = (pend_reg << 3) + (pend_reg << 1);

    always_comb begin
        pend_step = '0;
        sum_step  = fold;
        sign_step = sign_reg;
        case (b_kind_reg)
            pses_pkg::KIND_DIGIT: begin
                pend_step = pend_x10 + VALUE_WIDTH'(b_digit_reg);
                sum_step  = sum_reg;
            end
            pses_pkg::KIND_PLUS: begin
                sign_step = 1'b0;
            end
            pses_pkg::KIND_MINUS: begin
                sign_step = 1'b1;
            end
            pses_pkg::KIND_OPEN: begin
                if (b_push_reg) begin
                    sum_step  = '0;
                    sign_step = 1'b0;
                end
            end
            pses_pkg::KIND_CLOSE: begin
                if (b_pop_reg) begin
                    sum_step = frame[VALUE_WIDTH-1:0] + neg_if(fold, frame[VALUE_WIDTH]);
                end
            end
            default: begin
            end
        endcase
    end

    assign res_sum = sum_step + neg_if(pend_step, sign_step);

    generate
        if (VALUE_WIDTH >= OW) begin : g_trunc
            assign res_ext = res_sum[OW-1:0];
        end else begin : g_sext
            assign res_ext = {{(OW - VALUE_WIDTH){res_sum[VALUE_WIDTH-1]}}, res_sum};
        end
    endgenerate

    always_comb begin
        pend_next = pend_reg;
        sum_next  = sum_reg;
        sign_next = sign_reg;
        if (fire) begin
            if (b_last_reg) begin
                pend_next = '0;
                sum_next  = '0;
                sign_next = 1'b0;
            end else begin
                pend_next = pend_step;
                sum_next  = sum_step;
                sign_next = sign_step;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !res_ready;
        if (fire && b_last_reg) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            pend_reg      <= '0;
            sum_reg       <= '0;
            sign_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            b_valid_reg   <= b_valid_next;
            pend_reg      <= pend_next;
            sum_reg       <= sum_next;
            sign_reg      <= sign_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && b_last_reg) begin
            out_value_reg <= res_ext;
            out_error_reg <= b_err_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_value = out_value_reg;
    assign res_error = out_error_reg;

endmodule

// ===== hdl/paren_sum_expression_evaluator_unit.sv =====
// A final beat passes the queue, the execute stage registers and the output register.
// Throughput: one character beat per cycle unless a final character waits on a result
// not yet taken; the frame store's single read port and the execute stage set that rate.
// Reset: aresetn is synchronous and active low; it empties the queue, clears the
// running sum, pending number, sign, frame count and error, and drops m_tvalid.
module paren_sum_expression_evaluator_unit #(
    parameter int STACK_DEPTH = pses_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = pses_pkg::DEF_VALUE_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: [7:0] ch
    input  logic [pses_pkg::CH_WIDTH-1:0]      s_tdata,
    input  logic                               s_tlast,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: [31:0] value, [33:32] error, [39:34] zero
    output logic [pses_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

    // The front part classifies each character as it arrives and writes it
    // into a short queue. The back part pops one entry per cycle while not
    // stalled: its issue stage tracks the frame count and the first error of
    // the expression and starts the read of the frame that a close parenthesis
    // needs, and its execute stage folds numbers into the running sum. A frame
    // pushed by the execute stage in the same cycle as it is read is forwarded.

    pses_pkg::item_t                 front_item;
    pses_pkg::item_t                 head;
    logic                            q_not_full;
    logic                            head_valid;
    logic                            pop;
    logic [pses_pkg::OUT_WIDTH-1:0]  res_value;
    logic [pses_pkg::ERR_WIDTH-1:0]  res_error;

    pses_front u_front (
        .ch   (s_tdata),
        .last (s_tlast),
        .item (front_item)
    );

    // A beat is accepted whenever the queue has a free slot.
    assign s_tready = q_not_full;

    pses_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid),
        .push_item  (front_item),
        .not_full   (q_not_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // The back part only holds still when a final character meets a result
    // that has not yet been taken.
    pses_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_ready  (m_tready),
        .res_valid  (m_tvalid),
        .res_value  (res_value),
        .res_error  (res_error)
    );

    assign m_tdata = {
        {(pses_pkg::M_TDATA_WIDTH - pses_pkg::OUT_WIDTH - pses_pkg::ERR_WIDTH){1'b0}},
        res_error,
        res_value
    };

endmodule

// ===== hdl/pses_checker.sv =====
module pses_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [pses_pkg::CH_WIDTH-1:0]      s_tdata,
    input logic                               s_tlast,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [pses_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

    // Final characters taken in whose results have not yet been delivered.
    logic [3:0] open_reg, open_next;
    logic       last_in, res_out;

    assign last_in = s_tvalid && s_tready && s_tlast;
    assign res_out = m_tvalid && m_tready;

    always_comb begin
        open_next = open_reg;
        if (last_in && !res_out) begin
            open_next = open_reg + 1'b1;
        end else if (res_out && !last_in) begin
            open_next = open_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_next;
        end
    end

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat shown right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[pses_pkg::M_TDATA_WIDTH-1:pses_pkg::OUT_WIDTH
                             + pses_pkg::ERR_WIDTH] == '0)
        else $error("padding bits of result beat not zero");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> open_reg != '0)
        else $error("result beat without a final character before it");

endmodule

bind paren_sum_expression_evaluator_unit pses_checker u_pses_checker (.*);

// ===== tb/paren_sum_result_monitor.sv =====
module paren_sum_result_monitor
    import pses_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_tvalid,
    input  logic                     s_tready,
    // s_tdata: [7:0] ch
    input  logic [CH_WIDTH-1:0]      s_tdata,
    input  logic                     s_tlast,

    input  logic                     m_tvalid,
    input  logic                     m_tready,
    // m_tdata: [31:0] value, [33:32] error, [39:34] zero
    input  logic [M_TDATA_WIDTH-1:0] m_tdata,

    output int                       fail_count,
    output int                       outstanding
);

    localparam int FRAMES = DEF_STACK_DEPTH;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        logic [ERR_WIDTH-1:0] error;
    } outcome_t;

    // Results still owed by the block, oldest first.
    outcome_t             awaited_outcomes[$];

    // Evaluation state of the expression in progress.
    logic [OUT_WIDTH-1:0] pending_num;
    logic [OUT_WIDTH-1:0] running_total;
    logic                 minus_active;
    logic [OUT_WIDTH-1:0] frame_total [FRAMES];
    logic                 frame_minus [FRAMES];
    int                   open_frames;
    logic [ERR_WIDTH-1:0] first_error;
    int                   result_index;

    function automatic logic [OUT_WIDTH-1:0] apply_sign(input logic [OUT_WIDTH-1:0] v,
                                                        input logic neg);
        return neg ? -v : v;
    endfunction

    // Only the first error of an expression is kept.
    function automatic void note_error(input logic [ERR_WIDTH-1:0] code);
        if (first_error == ERR_NONE) begin
            first_error = code;
        end
    endfunction

    function automatic void restart_expression();
        pending_num   = '0;
        running_total = '0;
        minus_active  = 1'b0;
        open_frames   = 0;
        first_error   = ERR_NONE;
    endfunction

    function automatic void fold_pending();
        running_total = running_total + apply_sign(pending_num, minus_active);
        pending_num   = '0;
    endfunction

    function automatic void absorb_char(input logic [CH_WIDTH-1:0] c, input logic is_last);
        outcome_t finished;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            pending_num = pending_num * OUT_WIDTH'(DECIMAL_BASE) + OUT_WIDTH'(c - CHAR_ZERO);
        end else begin
            // Every non-digit, even one that is otherwise ignored, ends the number.
            fold_pending();
            case (c)
                CHAR_PLUS:  minus_active = 1'b0;
                CHAR_MINUS: minus_active = 1'b1;
                CHAR_OPEN: begin
                    if (open_frames >= FRAMES) begin
                        note_error(ERR_OVERFLOW);
                    end else begin
                        frame_total[open_frames] = running_total;
                        frame_minus[open_frames] = minus_active;
                        open_frames++;
                        running_total = '0;
                        minus_active  = 1'b0;
                    end
                end
                CHAR_CLOSE: begin
                    if (open_frames == 0) begin
                        note_error(ERR_UNMATCHED);
                    end else begin
                        open_frames--;
                        running_total = frame_total[open_frames] +
                                        apply_sign(running_total, frame_minus[open_frames]);
                    end
                end
                default: ;
            endcase
        end
        if (is_last) begin
            fold_pending();
            if (open_frames != 0) begin
                note_error(ERR_UNCLOSED);
            end
            finished.value = running_total;
            finished.error = first_error;
            awaited_outcomes.push_back(finished);
            restart_expression();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("result %0d: %s mismatch, got 0x%0h, expected 0x%0h",
                 result_index, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        outcome_t head;
        if (!aresetn) begin
            awaited_outcomes.delete();
            restart_expression();
            fail_count   = 0;
            result_index = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, '0);
                end else begin
                    head = awaited_outcomes.pop_front();
                    if (m_tdata[OUT_WIDTH-1:0] !== head.value) begin
                        report_mismatch("value", m_tdata[OUT_WIDTH-1:0], head.value);
                    end
                    if (m_tdata[OUT_WIDTH+:ERR_WIDTH] !== head.error) begin
                        report_mismatch("error", m_tdata[OUT_WIDTH+:ERR_WIDTH], head.error);
                    end
                    if (m_tdata[M_TDATA_WIDTH-1:OUT_WIDTH+ERR_WIDTH] !== '0) begin
                        report_mismatch("padding", m_tdata[M_TDATA_WIDTH-1:OUT_WIDTH+ERR_WIDTH],
                                        '0);
                    end
                end
                result_index++;
            end
            if (s_tvalid && s_tready) begin
                absorb_char(s_tdata, s_tlast);
            end
        end
        outstanding = awaited_outcomes.size();
    end

endmodule

// ===== tb/paren_sum_expression_evaluator_unit_test.sv =====
module paren_sum_expression_evaluator_unit_test;
    import pses_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int TARGET_ITEMS    = 950;
    // Past this many character beats both sides stop idling.
    localparam int CALM_AFTER      = 830;
    // The long receiver hold-off starts once this many beats have gone in.
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 200;
    // Cycles without any beat on either channel before the run is declared hung.
    localparam int QUIET_LIMIT     = 2000;
    // Wait after the last awaited result, to catch any stray result beat.
    localparam int DRAIN_CYCLES    = 8;
    localparam int FRAMES          = DEF_STACK_DEPTH;

    typedef logic [CH_WIDTH-1:0] char_t;

    localparam char_t CHAR_SPACE = 8'h20;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // s_tdata: [7:0] ch
    char_t                    s_tdata  = '0;
    logic                     s_tlast  = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // m_tdata: [31:0] value, [33:32] error, [39:34] zero
    logic [M_TDATA_WIDTH-1:0] m_tdata;

    // Set at each rising edge where a character beat was taken; read at the
    // following falling edge by the sender.
    logic                     s_took   = 1'b0;
    int                       items_sent = 0;
    logic                     calm;
    int                       fail_count;
    int                       outstanding;

    // Characters of the expression about to be sent.
    char_t                    expr_chars[$];

    assign calm = items_sent >= CALM_AFTER;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    paren_sum_expression_evaluator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    paren_sum_result_monitor monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        s_took <= s_tvalid && s_tready;
    end

    // Offers one character beat from a falling edge and returns at the falling
    // edge that follows its acceptance, so the next beat can be driven at once.
    task automatic send_beat(input char_t c, input logic is_last);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        @(negedge aclk);
        while (!s_took) begin
            @(negedge aclk);
        end
        items_sent++;
    endtask

    // Sends the whole expression with tlast on its final character. Random
    // idle bursts are put in front of any character, the first one included.
    task automatic send_expression();
        int i;
        for (i = 0; i < expr_chars.size(); i++) begin
            if (!calm && $urandom_range(0, 7) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
            send_beat(expr_chars[i], i == expr_chars.size() - 1);
        end
    endtask

    task automatic load_text(input string text);
        int i;
        expr_chars.delete();
        for (i = 0; i < text.len(); i++) begin
            expr_chars.push_back(text[i]);
        end
    endtask

    // Mostly short numbers; now and then one long enough to wrap 32 bits.
    task automatic append_number();
        int unsigned digits;
        digits = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
        repeat (digits) expr_chars.push_back(CHAR_ZERO + char_t'($urandom_range(0, 9)));
    endtask

    // Builds one random expression. Most are sums with balanced groups; the
    // rest leave groups open, close too many, nest right up to and past the
    // frame store's capacity, or are plain byte noise.
    task automatic compose_expression();
        int unsigned style;
        int unsigned depth;
        int unsigned opens;
        expr_chars.delete();
        opens = 0;
        style = $urandom_range(0, 99);
        if (style < 6) begin
            depth = $urandom_range(FRAMES - 1, FRAMES + 3);
            repeat (depth) begin
                if ($urandom_range(0, 3) == 0) begin
                    append_number();
                    expr_chars.push_back(CHAR_MINUS);
                end
                expr_chars.push_back(CHAR_OPEN);
            end
            append_number();
            repeat ($urandom_range(depth - 2, depth + 1)) expr_chars.push_back(CHAR_CLOSE);
        end else if (style < 12) begin
            repeat ($urandom_range(1, 12)) expr_chars.push_back(char_t'($urandom));
        end else begin
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(0, 11))
                    0, 1, 2, 3, 4: append_number();
                    5: expr_chars.push_back(CHAR_PLUS);
                    6: expr_chars.push_back(CHAR_MINUS);
                    7: begin
                        expr_chars.push_back(CHAR_OPEN);
                        opens++;
                    end
                    8: begin
                        if (opens != 0) begin
                            expr_chars.push_back(CHAR_CLOSE);
                            opens--;
                        end else begin
                            expr_chars.push_back(CHAR_PLUS);
                        end
                    end
                    9: expr_chars.push_back(CHAR_SPACE);
                    10: begin
                        expr_chars.push_back(CHAR_MINUS);
                        expr_chars.push_back(CHAR_OPEN);
                        opens++;
                    end
                    default: expr_chars.push_back(char_t'($urandom));
                endcase
            end
            if (style < 82) begin
                repeat (opens) expr_chars.push_back(CHAR_CLOSE);
            end else if (style < 91) begin
                // One close too many.
                repeat (opens + 1) expr_chars.push_back(CHAR_CLOSE);
            end
            // Otherwise the groups stay open to the end.
        end
        if (expr_chars.size() == 0) begin
            append_number();
        end
    endtask

    // Result side: ready stretches, short stall bursts, and once a long
    // hold-off so that the result path backs up and the input stalls while
    // the sender keeps offering beats.
    initial begin : result_sink
        bit held_off;
        held_off = 1'b0;
        @(negedge aclk);
        forever begin
            if (!held_off && items_sent >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
    end

    // Ends a run in which neither channel moves a beat for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge aresetn);
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("paren_sum_expression_evaluator_unit_test: FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // A close with nothing open, then a sign and a digit.
        load_text(")+3");
        send_expression();
        // Nested groups left open: the inner group's sum comes out.
        load_text("(-(8");
        send_expression();
        // A null and an all-ones byte split and end a number like a space.
        load_text("12");
        expr_chars.push_back(8'h00);
        expr_chars.push_back(CHAR_ZERO + char_t'(3));
        expr_chars.push_back(8'hFF);
        send_expression();
        // A balanced group with a negative result.
        load_text("(1-2)");
        send_expression();
        // The unmatched close is reported, not the open group after it.
        load_text(")(");
        send_expression();
        // A lone digit as the whole expression.
        load_text("9");
        send_expression();

        while (items_sent < TARGET_ITEMS) begin
            compose_expression();
            send_expression();
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("paren_sum_expression_evaluator_unit_test: PASS");
        end else begin
            $display("paren_sum_expression_evaluator_unit_test: FAIL");
        end
        $finish;
    end

endmodule
